/* src/ita_pkg.sv */
// ----------------------------------------------------------------------------
// ita_pkg: shared constants, types and helpers for the integer-to-text block
// Holds character codes, radix limits, the divider handshake structs and
// the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package ita_pkg;

  // Field widths
  localparam int RADIX_W  = 6;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 6;

  // Default value width
  localparam int VALUE_WIDTH_DEF = 32;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

  // Control into the serial divider
  typedef struct packed {
    logic load;   // take a new dividend, clear remainder
    logic step;   // advance one quotient bit
  } div_ctrl_t;

  // Status out of the serial divider
  typedef struct packed {
    logic done;       // this step finished one digit
    logic quot_zero;  // quotient after this digit is zero
  } div_stat_t;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DECIMAL_DIGITS) begin
      digit_char = CHAR_ZERO + d_ext;
    end else begin
      digit_char = CHAR_LOW_A + d_ext - {{(CHAR_W-DIGIT_W){1'b0}}, DECIMAL_DIGITS};
    end
  endfunction

endpackage

`default_nettype wire

/* src/ita_sdiv.sv */
// ----------------------------------------------------------------------------
// ita_sdiv: bit-serial restoring divider by a small radix
// Shifts the magnitude through one quotient bit per cycle while step is
// high; after VALUE_WIDTH steps the remainder is one digit and the
// quotient is kept in place for the next digit.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_sdiv
  import ita_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire div_ctrl_t              ctrl_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]     radix_i,
  output      div_stat_t              stat_o,
  output      logic [DIGIT_W-1:0]     digit_o
);

  localparam int BIT_W = $clog2(VALUE_WIDTH);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [BIT_W-1:0]       bit_q, bit_d;

  logic [DIGIT_W:0]       rem_sh;
  logic [DIGIT_W:0]       rem_nx;
  logic                   ge;
  logic [VALUE_WIDTH-1:0] quot_nx;
  logic                   last_bit;

  // Shift in the next dividend bit and trial-subtract the radix
  always_comb begin
    rem_sh   = {rem_q, mag_q[VALUE_WIDTH-1]};
    ge       = rem_sh >= {1'b0, radix_i};
    rem_nx   = ge ? (rem_sh - {1'b0, radix_i}) : rem_sh;
    quot_nx  = {mag_q[VALUE_WIDTH-2:0], ge};
    last_bit = (bit_q == BIT_LAST);
  end

  assign digit_o          = rem_nx[DIGIT_W-1:0];
  assign stat_o.done      = ctrl_i.step && last_bit;
  assign stat_o.quot_zero = (quot_nx == '0);

  // Next state of the shift registers
  always_comb begin
    mag_d = mag_q;
    rem_d = rem_q;
    bit_d = bit_q;
    if (ctrl_i.load) begin
      mag_d = dividend_i;
      rem_d = '0;
      bit_d = '0;
    end else if (ctrl_i.step) begin
      mag_d = quot_nx;
      if (last_bit) begin
        rem_d = '0;
        bit_d = '0;
      end else begin
        rem_d = rem_nx[DIGIT_W-1:0];
        bit_d = bit_q + 1'b1;
      end
    end
  end

  // Hold the bit counter under reset; data needs none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else begin
      bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

endmodule

`default_nettype wire

/* src/int_to_ascii_radix_core.sv */
// ----------------------------------------------------------------------------
// int_to_ascii_radix_core: signed integer to ASCII text in radix 2 to 36
// Converts one signed value per transaction and streams its characters,
// most significant first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
// Usage:
//   Write the radix on the cfg channel (cfg_valid_i / cfg_ready_o /
//   cfg_data_i) while the block is idle; it resets to 10.
//   Raise start with value_i while busy is low to begin a transaction.
//   Each character appears on character_o / last_char_o / bad_radix_o for
//   exactly one cycle with strobe_o high; last_char_o marks the final one.
//   The receiver cannot stall: it must take every strobed character.
// Timing:
//   An illegal radix gives one error character the cycle after start.
//   Otherwise the digits are divided out one by one in the bit-serial
//   divider, then every character is read back through the digit memory
//   (address, then registered read), most significant digit first.
//   The '-' is strobed as the last digit finishes dividing.
// Reset: returns to idle, drops any transaction in flight, radix = 10.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_ascii_radix_core
  import ita_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Command channel
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  // Configuration channel
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [RADIX_W-1:0]     cfg_data_i,
  // Result channel
  output      logic                   strobe_o,
  output      logic [CHAR_W-1:0]      character_o,
  output      logic                   last_char_o,
  output      logic                   bad_radix_o
);

  localparam int IDX_W = $clog2(VALUE_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               neg_q, neg_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [DIGIT_W-1:0] rd_data_q;

  logic               strobe_q, strobe_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;
  logic               bad_q, bad_d;

  logic               accept;
  logic               radix_ok;
  logic               value_neg;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic               mem_we;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [DIGIT_W-1:0] div_digit;

  logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  // Take radix writes only while idle and no command is offered
  assign cfg_ready_o = !busy && !start;

  assign radix_ok  = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
  assign value_neg = value_i[VALUE_WIDTH-1];
  // Unsigned magnitude; the most negative value maps to 2^(VALUE_WIDTH-1)
  assign magnitude = value_neg ? (~value_i + 1'b1) : value_i;

  ita_sdiv #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_sdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (magnitude),
    .radix_i    (radix_q),
    .stat_o     (div_stat),
    .digit_o    (div_digit)
  );

  // Sequence: divide out digits, then read them back in reverse
  always_comb begin
    state_d       = state_q;
    radix_d       = radix_q;
    neg_d         = neg_q;
    idx_d         = idx_q;
    strobe_d      = 1'b0;
    char_d        = char_q;
    last_d        = last_q;
    bad_d         = bad_q;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    mem_we        = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      radix_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!radix_ok) begin
            strobe_d = 1'b1;
            char_d   = CHAR_NONE;
            last_d   = 1'b1;
            bad_d    = 1'b1;
          end else begin
            div_ctrl.load = 1'b1;
            neg_d         = value_neg;
            idx_d         = '0;
            state_d       = S_DIV;
          end
        end
      end
      S_DIV: begin
        div_ctrl.step = 1'b1;
        if (div_stat.done) begin
          mem_we = 1'b1;
          if (div_stat.quot_zero) begin
            // Emit the sign while the last digit lands
            if (neg_q) begin
              strobe_d = 1'b1;
              char_d   = CHAR_MINUS;
              last_d   = 1'b0;
              bad_d    = 1'b0;
            end
            state_d = S_RD;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        strobe_d = 1'b1;
        char_d   = digit_char(rd_data_q);
        last_d   = (idx_q == '0);
        bad_d    = 1'b0;
        if (idx_q == '0) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      radix_q  <= RADIX_RESET;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      radix_q  <= radix_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
    bad_q  <= bad_d;
  end

  // Digit memory: write at the digit index, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[idx_q] <= div_digit;
    end
    rd_data_q <= digit_mem[idx_q];
  end

  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_char_o = last_q;
  assign bad_radix_o = bad_q;

endmodule

`default_nettype wire

/* dv/int_to_ascii_radix_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int_to_ascii_radix_checker: text predictor and scoreboard for the core
// Watches the radix write channel, the command channel and the character
// stream. Predicts the characters of every accepted value and compares each
// strobed character with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_checker
  import ita_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [RADIX_W-1:0]     cfg_data_i,
  input  logic                   strobe_i,
  input  logic [CHAR_W-1:0]      char_i,
  input  logic                   last_i,
  input  logic                   bad_i,
  output int                     err_count_o,
  output int                     pending_o
);

  localparam int MAX_REPORTS = 10;
  localparam int DIGIT_SLOTS = 64;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } text_char_t;

  text_char_t         text_q[$];
  logic [RADIX_W-1:0] radix_q = RADIX_RESET;
  int                 fails = 0;
  int                 waiting = 0;

  assign err_count_o = fails;
  assign pending_o   = waiting;

  // Queue the characters one value turns into under the current radix
  function automatic void queue_text(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] mag;
    logic [63:0]            rest;
    logic [63:0]            base;
    logic [DIGIT_W-1:0]     digs[DIGIT_SLOTS];
    logic [CHAR_W-1:0]      d_ext;
    text_char_t             c;
    int                     n;
    if (radix_q < RADIX_MIN || radix_q > RADIX_MAX) begin
      c = '{ch: CHAR_NONE, last: 1'b1, bad: 1'b1};
      text_q.push_back(c);
      return;
    end
    // Magnitude in VALUE_WIDTH bits: the most negative value maps to 2^(W-1)
    mag  = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    rest = 64'(mag);
    base = 64'(radix_q);
    n    = 0;
    do begin
      digs[n] = DIGIT_W'(rest % base);
      rest    = rest / base;
      n++;
    end while (rest != 0 && n < DIGIT_SLOTS);
    if (v[VALUE_WIDTH-1]) begin
      c = '{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0};
      text_q.push_back(c);
    end
    // Emit digits most significant first
    for (int i = n - 1; i >= 0; i--) begin
      d_ext = CHAR_W'(digs[i]);
      if (digs[i] < DECIMAL_DIGITS) begin
        c.ch = CHAR_ZERO + d_ext;
      end else begin
        c.ch = CHAR_LOW_A + d_ext - CHAR_W'(DECIMAL_DIGITS);
      end
      c.last = (i == 0);
      c.bad  = 1'b0;
      text_q.push_back(c);
    end
  endfunction

  // Count a failure, report only the first few
  task automatic flag_error(input string what, input text_char_t exp_c, input text_char_t got_c);
    fails++;
    if (fails <= MAX_REPORTS) begin
      $display("%0t checker: %s: expected ch=%02h last=%0b bad=%0b, got ch=%02h last=%0b bad=%0b",
               $realtime, what, exp_c.ch, exp_c.last, exp_c.bad,
               got_c.ch, got_c.last, got_c.bad);
    end
  endtask

  // Track radix writes, predict on accepted commands, compare strobed characters
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t got_c;
    text_char_t exp_c;
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      text_q.delete();
      waiting = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        radix_q = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        queue_text(value_i);
      end
      if (strobe_i) begin
        got_c = '{ch: char_i, last: last_i, bad: bad_i};
        if (text_q.size() == 0) begin
          flag_error("character with nothing pending", '0, got_c);
        end else begin
          exp_c = text_q.pop_front();
          if (got_c.ch !== exp_c.ch) begin
            flag_error("character mismatch", exp_c, got_c);
          end else if (got_c.last !== exp_c.last) begin
            flag_error("last_char mismatch", exp_c, got_c);
          end else if (got_c.bad !== exp_c.bad) begin
            flag_error("bad_radix mismatch", exp_c, got_c);
          end
        end
      end
      waiting = text_q.size();
    end
  end

endmodule

/* dv/int_to_ascii_radix_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int_to_ascii_radix_core_tb: stimulus and verdict for the itoa core
// Drives directed and random values through several radix settings, legal
// and illegal, with random gaps between commands. A checker beside the core
// predicts and compares every character; a watchdog catches stalls.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_core_tb;
  import ita_pkg::*;

  localparam int VALUE_W     = VALUE_WIDTH_DEF;
  localparam int STALL_LIMIT = 6000;
  localparam int TAIL_CYCLES = 50;
  localparam int GAP_MAX     = 17;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 23;

  logic               clk;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data;
  logic               strobe;
  logic [CHAR_W-1:0]  char_out;
  logic               last_char;
  logic               bad_radix;
  int                 err_count;
  int                 pending;
  int                 gap_limit = GAP_MAX;
  int                 idle_cycles = 0;

  int_to_ascii_radix_core #(
    .VALUE_WIDTH(VALUE_W)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .strobe_o   (strobe),
    .character_o(char_out),
    .last_char_o(last_char),
    .bad_radix_o(bad_radix)
  );

  int_to_ascii_radix_checker #(
    .VALUE_WIDTH(VALUE_W)
  ) checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .value_i    (value),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .strobe_i   (strobe),
    .char_i     (char_out),
    .last_i     (last_char),
    .bad_i      (bad_radix),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if (!rst_ni || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("int_to_ascii_radix_core_tb: errors");
      $finish;
    end
  end

  // Hold off until every predicted character has come out and the core is idle
  task automatic drain();
    start = 1'b0;
    while (pending != 0 || busy) begin
      @(negedge clk);
    end
  endtask

  // Issue one conversion after a random gap; return at the next falling edge
  task automatic convert_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    value = v;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Write the radix register once the core has gone idle
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = $urandom_range(0, 63);
  endtask

  // Mix of wide random, small, extreme and shifted values
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: v = VALUE_W'($urandom_range(0, 40));
      2: v = -VALUE_W'($urandom_range(1, 40));
      3: begin
        case ($urandom_range(0, 4))
          0: v = {1'b1, {(VALUE_W-1){1'b0}}};
          1: v = {1'b0, {(VALUE_W-1){1'b1}}};
          2: v = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
          3: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        v = $urandom() >> $urandom_range(0, VALUE_W - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Radix for one random phase: fixed corners, random legal and illegal, then the reset radix
  function automatic logic [RADIX_W-1:0] phase_radix(input int p);
    logic [RADIX_W-1:0] r;
    case (p)
      0: r = RADIX_MIN;
      1: r = RADIX_MAX;
      2: r = RADIX_W'($urandom_range(3, 9));
      3: r = RADIX_W'($urandom_range(11, 35));
      4: r = ($urandom_range(0, 1)) ? RADIX_W'($urandom_range(0, 1))
                                    : RADIX_W'($urandom_range(37, 63));
      5: r = RADIX_W'($urandom_range(0, 63));
      default: r = RADIX_RESET;
    endcase
    return r;
  endfunction

  initial begin
    logic [RADIX_W-1:0] r;
    rst_ni    = 1'b0;
    start     = 1'b0;
    value     = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst_ni = 1'b1;

    // Reset radix: zero, unit values, extremes, a carry into a new digit
    convert_value('0);
    convert_value(VALUE_W'(1));
    convert_value('1);
    convert_value({1'b0, {(VALUE_W-1){1'b1}}});
    convert_value({1'b1, {(VALUE_W-1){1'b0}}});
    convert_value(VALUE_W'(9));
    convert_value(-VALUE_W'(10));

    // Largest radix: top digit 'z' and the two-digit rollover
    set_radix(RADIX_MAX);
    convert_value(VALUE_W'(35));
    convert_value(-VALUE_W'(36));
    convert_value({1'b1, {(VALUE_W-1){1'b0}}});
    convert_value({1'b0, {(VALUE_W-1){1'b1}}});
    convert_value('0);

    // Smallest radix: longest text
    set_radix(RADIX_MIN);
    convert_value({1'b1, {(VALUE_W-1){1'b0}}});
    convert_value('1);
    convert_value({1'b0, {(VALUE_W-1){1'b1}}});

    set_radix(RADIX_W'(16));
    convert_value(VALUE_W'(255));
    convert_value(-VALUE_W'(256));

    // Illegal radix values at both ends and the all-ones register
    set_radix(RADIX_W'(0));
    convert_value(VALUE_W'(5));
    set_radix(RADIX_W'(1));
    convert_value('0);
    set_radix(RADIX_W'(37));
    convert_value('1);
    set_radix('1);
    convert_value(VALUE_W'(7));

    // Random phases; one runs back to back, each drains once midway
    for (int p = 0; p < PHASES; p++) begin
      r = phase_radix(p);
      set_radix(r);
      gap_limit = (p == 3) ? 0 : GAP_MAX;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain();
        convert_value(pick_value());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("int_to_ascii_radix_core_tb: clean");
    end else begin
      $display("int_to_ascii_radix_core_tb: errors");
    end
    $finish;
  end

endmodule
